// ===== rtl/core/plfs_pkg.sv =====
`timescale 1ns / 1ps

package plfs_pkg;

   // Fixed geometry of the line state and the duration table.
   localparam int SLOTS    = 16;
   localparam int LINE_W   = 4;
   localparam int FRAME_W  = 4;
   localparam int TICK_W   = 8;
   localparam int VALUE_W  = 8;
   localparam int OP_W     = 3;
   localparam int MASK_W   = 16;
   localparam int DUR_AW   = LINE_W + FRAME_W;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
   localparam logic [OP_W-1:0] OP_SET_COUNT = 3'd1;
   localparam logic [OP_W-1:0] OP_WRITE_DUR = 3'd2;
   localparam logic [OP_W-1:0] OP_READ_LINE = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              load_req;     // capture the request fields
      logic              exec_op;      // execute a non-tick operation
      logic              issue;        // start the table read for issue_line
      logic [LINE_W-1:0] issue_line;
      logic              update;       // update the counters of update_line
      logic [LINE_W-1:0] update_line;
      logic              finish_tick;  // load the tick result
   } cmd_type;

endpackage

// ===== rtl/core/plfs_ctrl.sv =====
`timescale 1ns / 1ps

module plfs_ctrl #(
   parameter int LINES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [plfs_pkg::OP_W-1:0] req_op,
   output logic                   busy,
   output plfs_pkg::cmd_type      cmd
);
   import plfs_pkg::*;

   localparam int IDX_W = $clog2(LINES + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_TICK = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              upd_ff, upd_in;
   logic [LINE_W-1:0] upd_line_ff, upd_line_in;
   logic              issue;
   logic [LINE_W-1:0] issue_line;

   assign busy       = (state_ff != ST_IDLE);
   assign issue      = (state_ff == ST_TICK) && (idx_ff < IDX_W'(LINES));
   assign issue_line = LINE_W'(idx_ff);

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      upd_in      = 1'b0;
      upd_line_in = upd_line_ff;
      cmd         = '0;
      cmd.issue_line  = issue_line;
      cmd.update_line = upd_line_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               idx_in       = '0;
               state_in     = (req_op == OP_TICK) ? ST_TICK : ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec_op = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_TICK: begin
            // The table read for one line overlaps the update of the line before it.
            cmd.issue   = issue;
            cmd.update  = upd_ff;
            upd_in      = issue;
            upd_line_in = issue_line;
            if (issue) begin
               idx_in = idx_ff + IDX_W'(1);
            end else if (upd_ff) begin
               cmd.finish_tick = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         upd_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         upd_ff   <= upd_in;
      end
   end

   always_ff @(posedge clock) begin
      upd_line_ff <= upd_line_in;
   end

endmodule

// ===== rtl/core/plfs_datapath.sv =====
`timescale 1ns / 1ps

module plfs_datapath #(
   parameter int LINES      = 16,
   parameter int MAX_FRAMES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  plfs_pkg::cmd_type             cmd,
   input  logic [plfs_pkg::OP_W-1:0]     req_op,
   input  logic [plfs_pkg::LINE_W-1:0]   req_line,
   input  logic [plfs_pkg::FRAME_W-1:0]  req_frame_index,
   input  logic [plfs_pkg::VALUE_W-1:0]  req_value,
   output logic                          rsp_valid,
   output logic                          rsp_any_advanced,
   output logic [plfs_pkg::MASK_W-1:0]   rsp_advanced_mask,
   output logic [plfs_pkg::FRAME_W-1:0]  rsp_current_frame,
   output logic [plfs_pkg::TICK_W-1:0]   rsp_current_ticks
);
   import plfs_pkg::*;

   localparam int TOT_W = $clog2(MAX_FRAMES + 1);

   // Latched request.
   logic [OP_W-1:0]    op_ff;
   logic [LINE_W-1:0]  line_ff;
   logic [FRAME_W-1:0] fidx_ff;
   logic [VALUE_W-1:0] value_ff;

   // Per-line state and the duration table.
   logic [TOT_W-1:0]   total_ff [SLOTS];
   logic [TICK_W-1:0]  cnt_ff   [SLOTS];
   logic [FRAME_W-1:0] pos_ff   [SLOTS];
   logic [TICK_W-1:0]  dur_mem  [2**DUR_AW];

   logic [TICK_W-1:0]  dur_q_ff;
   logic [FRAME_W-1:0] pos_q_ff;
   logic [MASK_W-1:0]  mask_ff, mask_in;

   logic               rsp_valid_ff;
   logic               rsp_any_ff;
   logic [MASK_W-1:0]  rsp_mask_ff;
   logic [FRAME_W-1:0] rsp_frame_ff;
   logic [TICK_W-1:0]  rsp_ticks_ff;

   logic [LINE_W-1:0]  pos_addr, cnt_addr;
   logic [FRAME_W-1:0] pos_rd;
   logic [TICK_W-1:0]  cnt_rd;
   logic [TOT_W-1:0]   total_rd;
   logic [TICK_W-1:0]  cnt_inc;
   logic [FRAME_W:0]   pos_plus;
   logic               active, hit, wrap;
   logic [FRAME_W-1:0] pos_next;
   logic               line_ok;
   logic [TOT_W-1:0]   count_sat;

   assign pos_addr = cmd.issue ? cmd.issue_line : line_ff;
   assign cnt_addr = cmd.update ? cmd.update_line : line_ff;
   assign pos_rd   = pos_ff[pos_addr];
   assign cnt_rd   = cnt_ff[cnt_addr];
   assign total_rd = total_ff[cmd.update_line];

   // Counter step for the line being updated.
   assign active   = (total_rd != '0);
   assign cnt_inc  = cnt_rd + TICK_W'(1);
   assign hit      = active && (cnt_inc == dur_q_ff);
   assign pos_plus = {1'b0, pos_q_ff} + (FRAME_W+1)'(1);
   assign wrap     = (pos_q_ff == {FRAME_W{1'b1}}) ||
                     (9'(pos_plus) == 9'(total_rd));
   assign pos_next = wrap ? '0 : pos_plus[FRAME_W-1:0];

   assign line_ok   = ({1'b0, line_ff} < (LINE_W+1)'(LINES));
   assign count_sat = (value_ff > VALUE_W'(MAX_FRAMES)) ? TOT_W'(MAX_FRAMES)
                                                         : TOT_W'(value_ff);

   always_comb begin
      mask_in = mask_ff;
      if (cmd.load_req) begin
         mask_in = '0;
      end else if (cmd.update && hit) begin
         mask_in[cmd.update_line] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff    <= req_op;
         line_ff  <= req_line;
         fidx_ff  <= req_frame_index;
         value_ff <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec_op && op_ff == OP_WRITE_DUR && line_ok) begin
         dur_mem[{line_ff, fidx_ff}] <= value_ff;
      end
      if (cmd.issue) begin
         dur_q_ff <= dur_mem[{cmd.issue_line, pos_rd}];
         pos_q_ff <= pos_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            total_ff[i] <= '0;
            cnt_ff[i]   <= '0;
            pos_ff[i]   <= '0;
         end
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
         if (cmd.update && active) begin
            cnt_ff[cmd.update_line] <= hit ? '0 : cnt_inc;
            if (hit) begin
               pos_ff[cmd.update_line] <= pos_next;
            end
         end
         if (cmd.exec_op) begin
            if (op_ff == OP_SET_COUNT && line_ok) begin
               total_ff[line_ff] <= count_sat;
               cnt_ff[line_ff]   <= '0;
               pos_ff[line_ff]   <= '0;
            end else if (op_ff == OP_CLEAR) begin
               for (int i = 0; i < SLOTS; i++) begin
                  cnt_ff[i] <= '0;
                  pos_ff[i] <= '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.exec_op || cmd.finish_tick;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish_tick) begin
         rsp_any_ff   <= (mask_in != '0);
         rsp_mask_ff  <= mask_in;
         rsp_frame_ff <= '0;
         rsp_ticks_ff <= '0;
      end else if (cmd.exec_op) begin
         rsp_any_ff  <= 1'b0;
         rsp_mask_ff <= '0;
         if (op_ff == OP_READ_LINE && line_ok) begin
            rsp_frame_ff <= pos_rd;
            rsp_ticks_ff <= cnt_rd;
         end else begin
            rsp_frame_ff <= '0;
            rsp_ticks_ff <= '0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_any_advanced  = rsp_any_ff;
   assign rsp_advanced_mask = rsp_mask_ff;
   assign rsp_current_frame = rsp_frame_ff;
   assign rsp_current_ticks = rsp_ticks_ff;

endmodule

// ===== rtl/core/palette_line_frame_sequencer_unit.sv =====
`timescale 1ns / 1ps
// A tick request sweeps the lines in order, one line per cycle; the table read for each
// line overlaps the update of the line before it, and with the last update the advance
// mask is registered as the result. Other requests execute in the EXEC state.
// Throughput: one request at a time; busy drops in the cycle of the strobe, so a new
// request is taken then. The result strobe lasts one cycle and cannot be held off.
// Reset: synchronous, active high; clears line counts, counters and frame indices.

module palette_line_frame_sequencer_unit #(
   parameter int LINES      = 16,
   parameter int MAX_FRAMES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [plfs_pkg::OP_W-1:0]     req_op,
   input  logic [plfs_pkg::LINE_W-1:0]   req_line,
   input  logic [plfs_pkg::FRAME_W-1:0]  req_frame_index,
   input  logic [plfs_pkg::VALUE_W-1:0]  req_value,
   output logic                          rsp_valid,
   output logic                          rsp_any_advanced,
   output logic [plfs_pkg::MASK_W-1:0]   rsp_advanced_mask,
   output logic [plfs_pkg::FRAME_W-1:0]  rsp_current_frame,
   output logic [plfs_pkg::TICK_W-1:0]   rsp_current_ticks
);
   import plfs_pkg::*;

   // The controller sequences each request. A tick sweeps the lines in order:
   // in each cycle it starts the duration-table read for one line and updates
   // the counters of the line before it with the duration that came back.
   cmd_type cmd;

   plfs_ctrl #(
      .LINES (LINES)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .busy   (busy),
      .cmd    (cmd)
   );

   // The datapath holds the request, the per-line counters, the duration table
   // and the result registers that drive the response ports.
   plfs_datapath #(
      .LINES      (LINES),
      .MAX_FRAMES (MAX_FRAMES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_op            (req_op),
      .req_line          (req_line),
      .req_frame_index   (req_frame_index),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_any_advanced  (rsp_any_advanced),
      .rsp_advanced_mask (rsp_advanced_mask),
      .rsp_current_frame (rsp_current_frame),
      .rsp_current_ticks (rsp_current_ticks)
   );

endmodule

// ===== rtl/core/plfs_checker.sv =====
`timescale 1ns / 1ps

module plfs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic                          rsp_any_advanced,
   input logic [plfs_pkg::MASK_W-1:0]   rsp_advanced_mask
);
   import plfs_pkg::*;

   // An accepted request keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   // A result is strobed only once the block is no longer busy.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // Every finished request delivers its result as busy drops.
   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("request finished without a result");

   // The any flag agrees with the advance mask.
   a_any_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_any_advanced == (rsp_advanced_mask != '0)))
      else $error("any flag disagrees with mask");

endmodule

bind palette_line_frame_sequencer_unit plfs_checker u_plfs_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_any_advanced  (rsp_any_advanced),
   .rsp_advanced_mask (rsp_advanced_mask)
);
